// ===== hw/rtl/hsvg_pkg.sv =====
package hsvg_pkg;

  // field widths
  localparam int unsigned COORD_W   = 11;
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CHAN_W    = 8;

  // register map
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  // register reset values before clamping
  localparam int unsigned FRAME_WIDTH_RST  = 800;
  localparam int unsigned FRAME_HEIGHT_RST = 600;

  // value ramp: v = VALUE_BASE + 179 * row / height, saturating
  localparam int unsigned VALUE_BASE = 77;
  localparam int unsigned VALUE_SPAN = 179;
  localparam int unsigned VALUE_SPAN_W = 8;

  // hue is col * HUE_SEGMENTS * 2^F / width
  localparam int unsigned HUE_SEGMENTS = 6;
  localparam int unsigned HUE_SEG_MUL_W = 3;

  typedef enum logic [2:0] {
    SEG_RED_TO_YELLOW    = 3'd0,
    SEG_YELLOW_TO_GREEN  = 3'd1,
    SEG_GREEN_TO_CYAN    = 3'd2,
    SEG_CYAN_TO_BLUE     = 3'd3,
    SEG_BLUE_TO_MAGENTA  = 3'd4,
    SEG_MAGENTA_TO_RED   = 3'd5
  } hue_seg_e;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

endpackage

// ===== hw/rtl/hsvg_div_pipe.sv =====
module hsvg_div_pipe #(
  parameter int unsigned NUM_W  = 22,
  parameter int unsigned DEN_W  = 12,
  parameter int unsigned STAGES = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             valid_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned BPS   = (NUM_W + STAGES - 1) / STAGES;
  localparam int unsigned PAD_W = BPS * STAGES;

  logic             vld_q [STAGES];
  logic [PAD_W-1:0] num_q [STAGES];
  logic [DEN_W-1:0] rem_q [STAGES];
  logic [PAD_W-1:0] quo_q [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic             vld_in;
    logic [PAD_W-1:0] num_in;
    logic [DEN_W-1:0] rem_in;
    logic [PAD_W-1:0] quo_in;
    logic [PAD_W-1:0] num_d;
    logic [DEN_W-1:0] rem_d;
    logic [PAD_W-1:0] quo_d;
    logic [DEN_W:0]   part;

    if (s == 0) begin : g_first
      assign vld_in = valid_i;
      assign num_in = PAD_W'(num_i);
      assign rem_in = '0;
      assign quo_in = '0;
    end else begin : g_next
      assign vld_in = vld_q[s-1];
      assign num_in = num_q[s-1];
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    // restoring division, BPS quotient bits per stage, msb first
    always_comb begin
      num_d = num_in;
      rem_d = rem_in;
      quo_d = quo_in;
      part  = '0;
      for (int b = 0; b < BPS; b++) begin
        part  = {rem_d, num_d[PAD_W-1]};
        num_d = num_d << 1;
        if (part >= {1'b0, den_i}) begin
          part  = part - {1'b0, den_i};
          quo_d = {quo_d[PAD_W-2:0], 1'b1};
        end else begin
          quo_d = {quo_d[PAD_W-2:0], 1'b0};
        end
        rem_d = part[DEN_W-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s] <= num_d;
        rem_q[s] <= rem_d;
        quo_q[s] <= quo_d;
      end
    end
  end

  assign valid_o = vld_q[STAGES-1];
  assign quo_o   = quo_q[STAGES-1][NUM_W-1:0];

endmodule

// ===== hw/rtl/hsvg_shade.sv =====
module hsvg_shade #(
  parameter int unsigned FRAC_W = 8,
  parameter int unsigned HUE_W  = 22,
  parameter int unsigned VQ_W   = 19
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [HUE_W-1:0]  hue_i,
  input  logic [VQ_W-1:0]   vquo_i,
  output logic              valid_o,
  output hsvg_pkg::rgb_t    rgb_o
);

  localparam int unsigned SEG_W  = HUE_W - FRAC_W;
  localparam int unsigned PROD_W = hsvg_pkg::CHAN_W + FRAC_W + 1;

  logic [SEG_W-1:0]            seg_full;
  logic [FRAC_W-1:0]           frac;
  hsvg_pkg::hue_seg_e          seg_d, seg_q;
  logic [FRAC_W:0]             fsel_d, fsel_q;
  logic [hsvg_pkg::CHAN_W-1:0] v_d, v_q;
  logic                        vld_q;
  logic [PROD_W-1:0]           prod;
  logic [hsvg_pkg::CHAN_W-1:0] xc;

  assign seg_full = hue_i[HUE_W-1:FRAC_W];
  assign frac     = hue_i[FRAC_W-1:0];

  always_comb begin
    // every segment past the fifth shares the last case
    if (seg_full > SEG_W'(hsvg_pkg::SEG_BLUE_TO_MAGENTA)) begin
      seg_d = hsvg_pkg::SEG_MAGENTA_TO_RED;
    end else begin
      seg_d = hsvg_pkg::hue_seg_e'(seg_full[2:0]);
    end
    // odd segments ramp down, parity of the unclamped segment
    if (seg_full[0]) begin
      fsel_d = ((FRAC_W + 1)'(1) << FRAC_W) - {1'b0, frac};
    end else begin
      fsel_d = {1'b0, frac};
    end
    if (vquo_i > VQ_W'(hsvg_pkg::VALUE_SPAN - 1)) begin
      v_d = '1;
    end else begin
      v_d = hsvg_pkg::CHAN_W'(hsvg_pkg::VALUE_BASE) + vquo_i[hsvg_pkg::CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      seg_q  <= seg_d;
      fsel_q <= fsel_d;
      v_q    <= v_d;
    end
  end

  assign prod = PROD_W'(v_q) * PROD_W'(fsel_q);
  assign xc   = prod[FRAC_W+hsvg_pkg::CHAN_W-1:FRAC_W];

  always_comb begin
    case (seg_q)
      hsvg_pkg::SEG_RED_TO_YELLOW: begin
        rgb_o = '{red: v_q, green: xc, blue: '0};
      end
      hsvg_pkg::SEG_YELLOW_TO_GREEN: begin
        rgb_o = '{red: xc, green: v_q, blue: '0};
      end
      hsvg_pkg::SEG_GREEN_TO_CYAN: begin
        rgb_o = '{red: '0, green: v_q, blue: xc};
      end
      hsvg_pkg::SEG_CYAN_TO_BLUE: begin
        rgb_o = '{red: '0, green: xc, blue: v_q};
      end
      hsvg_pkg::SEG_BLUE_TO_MAGENTA: begin
        rgb_o = '{red: xc, green: '0, blue: v_q};
      end
      default: begin
        rgb_o = '{red: v_q, green: '0, blue: xc};
      end
    endcase
  end

  assign valid_o = vld_q;

endmodule

// ===== hw/rtl/hsvg_skid.sv =====
module hsvg_skid (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  hsvg_pkg::rgb_t data_i,
  output logic           ready_o,
  output logic           valid_o,
  input  logic           stall_i,
  output hsvg_pkg::rgb_t data_o
);

  logic           out_vld_d, out_vld_q;
  logic           skid_vld_d, skid_vld_q;
  hsvg_pkg::rgb_t out_d, out_q;
  hsvg_pkg::rgb_t skid_d, skid_q;
  logic           take;
  logic           push;

  assign take    = out_vld_q && !stall_i;
  assign push    = valid_i && !skid_vld_q;
  assign ready_o = !skid_vld_q;

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (skid_vld_q) begin
      if (take) begin
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (push) begin
      if (!out_vld_q || take) begin
        out_d     = data_i;
        out_vld_d = 1'b1;
      end else begin
        skid_d     = data_i;
        skid_vld_d = 1'b1;
      end
    end else if (take) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign valid_o = out_vld_q;
  assign data_o  = out_q;

endmodule

// ===== hw/rtl/hsv_rainbow_gradient_pixel_top.sv =====
// channel   | valid        | stall        | payload
// ----------+--------------+--------------+---------------------------------------
// pixel in  | in_valid_i   | in_stall_o   | pixel_col_i, pixel_row_i
// color out | out_valid_o  | out_stall_i  | red_o, green_o, blue_o
// config    | cfg_we_i     | (none)       | cfg_idx_i, cfg_wdata_i
//
// one pixel per cycle sustained while the skid entry is empty; the path runs through
// an input register, the pipelined long dividers for hue and value, and the shade stage
// rst_ni clears all valid bits and loads frame 800 x 600; no clearing pass
// an output register plus a skid entry sit at the end; in_stall_o rises only
// once the skid entry holds an item, and then the whole pipeline holds
module hsv_rainbow_gradient_pixel_top #(
  parameter int unsigned MAX_DIMENSION     = 2048,
  parameter int unsigned HUE_FRACTION_BITS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // config write port
  input  logic                               cfg_we_i,
  input  logic [hsvg_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [hsvg_pkg::CFG_W-1:0]         cfg_wdata_i,
  // pixel coordinate in
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [hsvg_pkg::COORD_W-1:0]       pixel_col_i,
  input  logic [hsvg_pkg::COORD_W-1:0]       pixel_row_i,
  // color out
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [hsvg_pkg::CHAN_W-1:0]        red_o,
  output logic [hsvg_pkg::CHAN_W-1:0]        green_o,
  output logic [hsvg_pkg::CHAN_W-1:0]        blue_o
);

  // effective dimensions are kept already clamped to 1..MAX_DIMENSION
  localparam int unsigned DIM_W = $clog2(MAX_DIMENSION + 1);
  localparam int unsigned WIDTH_RST =
      (hsvg_pkg::FRAME_WIDTH_RST > MAX_DIMENSION) ? MAX_DIMENSION : hsvg_pkg::FRAME_WIDTH_RST;
  localparam int unsigned HEIGHT_RST =
      (hsvg_pkg::FRAME_HEIGHT_RST > MAX_DIMENSION) ? MAX_DIMENSION : hsvg_pkg::FRAME_HEIGHT_RST;

  // hue numerator col * 6 * 2^F, value numerator 179 * row
  localparam int unsigned HUE_MUL_W  = hsvg_pkg::COORD_W + hsvg_pkg::HUE_SEG_MUL_W;
  localparam int unsigned HUE_NUM_W  = HUE_MUL_W + HUE_FRACTION_BITS;
  localparam int unsigned VAL_NUM_W  = hsvg_pkg::COORD_W + hsvg_pkg::VALUE_SPAN_W;
  // about four quotient bits per divider stage
  localparam int unsigned DIV_STAGES = (HUE_NUM_W + 3) / 4;

  logic [DIM_W-1:0]     width_q, height_q;
  logic [DIM_W-1:0]     dim_wr;

  logic                 adv;
  logic                 in_vld_q;
  logic [HUE_NUM_W-1:0] hue_num_q;
  logic [VAL_NUM_W-1:0] val_num_q;

  logic                 hue_vld;
  logic [HUE_NUM_W-1:0] hue_quo;
  logic                 val_vld;
  logic [VAL_NUM_W-1:0] val_quo;

  logic                 shade_vld;
  hsvg_pkg::rgb_t       shade_rgb;
  hsvg_pkg::rgb_t       out_rgb;

  // ---------------------------------------------------------------------------
  // config registers, clamped on write (zero reads as one, oversize as max)
  // ---------------------------------------------------------------------------
  always_comb begin
    if (cfg_wdata_i == '0) begin
      dim_wr = DIM_W'(1);
    end else if (32'(cfg_wdata_i) > MAX_DIMENSION) begin
      dim_wr = DIM_W'(MAX_DIMENSION);
    end else begin
      dim_wr = DIM_W'(32'(cfg_wdata_i));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(WIDTH_RST);
      height_q <= DIM_W'(HEIGHT_RST);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hsvg_pkg::CFG_FRAME_WIDTH:  width_q  <= dim_wr;
        hsvg_pkg::CFG_FRAME_HEIGHT: height_q <= dim_wr;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline control: everything moves together unless the skid entry is full
  // ---------------------------------------------------------------------------
  assign in_stall_o = !adv;

  // input stage forms both numerators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (adv) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hue_num_q <= {HUE_MUL_W'(pixel_col_i) * HUE_MUL_W'(hsvg_pkg::HUE_SEGMENTS),
                    {HUE_FRACTION_BITS{1'b0}}};
      val_num_q <= VAL_NUM_W'(pixel_row_i) * VAL_NUM_W'(hsvg_pkg::VALUE_SPAN);
    end
  end

  // ---------------------------------------------------------------------------
  // hue and value dividers run side by side with the same stage count
  // ---------------------------------------------------------------------------
  hsvg_div_pipe #(
    .NUM_W  (HUE_NUM_W),
    .DEN_W  (DIM_W),
    .STAGES (DIV_STAGES)
  ) u_hue_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_vld_q),
    .num_i   (hue_num_q),
    .den_i   (width_q),
    .valid_o (hue_vld),
    .quo_o   (hue_quo)
  );

  hsvg_div_pipe #(
    .NUM_W  (VAL_NUM_W),
    .DEN_W  (DIM_W),
    .STAGES (DIV_STAGES)
  ) u_val_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_vld_q),
    .num_i   (val_num_q),
    .den_i   (height_q),
    .valid_o (val_vld),
    .quo_o   (val_quo)
  );

  // segment, fraction and value, then the x term multiply and channel select
  hsvg_shade #(
    .FRAC_W (HUE_FRACTION_BITS),
    .HUE_W  (HUE_NUM_W),
    .VQ_W   (VAL_NUM_W)
  ) u_shade (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (hue_vld),
    .hue_i   (hue_quo),
    .vquo_i  (val_quo),
    .valid_o (shade_vld),
    .rgb_o   (shade_rgb)
  );

  // output register plus skid entry
  hsvg_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (shade_vld),
    .data_i  (shade_rgb),
    .ready_o (adv),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_rgb)
  );

  assign red_o   = out_rgb.red;
  assign green_o = out_rgb.green;
  assign blue_o  = out_rgb.blue;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // both dividers carry the same items
  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hue_vld == val_vld)
    else $error("hue and value dividers out of step");

  // input only stalls when the output register is also full
  a_stall_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output register");

  // a full skid with a stalled output keeps the input stalled
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_stall_o && out_stall_i) |=> in_stall_o)
    else $error("skid entry dropped while output stalled");

  // divisors never reach zero or exceed the maximum
  a_dims_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (width_q != '0) && (height_q != '0) &&
    (32'(width_q) <= MAX_DIMENSION) && (32'(height_q) <= MAX_DIMENSION))
    else $error("frame dimension out of range");

endmodule

// ===== tb/hsv_rainbow_gradient_pixel_top_tb.sv =====
module hsv_rainbow_gradient_pixel_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // block parameters, kept at their defaults
  localparam int unsigned MAX_DIM = 2048;
  localparam int unsigned HUE_F   = 8;

  // register indexes with no register behind them
  localparam logic [hsvg_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [hsvg_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 73;
  // idle wait at the end, for late or stray colors
  localparam int DRAIN_CYCLES    = 20;
  // cycles without any accepted item before the run is abandoned
  localparam int STALE_LIMIT     = 2000;

  typedef struct {
    logic [hsvg_pkg::COORD_W-1:0] col;
    logic [hsvg_pkg::COORD_W-1:0] row;
  } pixel_t;

  typedef struct {
    pixel_t         pix;
    hsvg_pkg::rgb_t rgb;
  } color_exp_t;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           cfg_we_i    = 1'b0;
  logic [hsvg_pkg::CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [hsvg_pkg::CFG_W-1:0]     cfg_wdata_i = '0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_stall_o;
  logic [hsvg_pkg::COORD_W-1:0]   pixel_col_i = '0;
  logic [hsvg_pkg::COORD_W-1:0]   pixel_row_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [hsvg_pkg::CHAN_W-1:0]    red_o;
  logic [hsvg_pkg::CHAN_W-1:0]    green_o;
  logic [hsvg_pkg::CHAN_W-1:0]    blue_o;

  // pixels waiting to be sent, and colors waiting to come back
  pixel_t     pixel_q[$];
  color_exp_t color_exp_q[$];

  // our copy of the frame registers, reset values as the block loads them
  logic [hsvg_pkg::CFG_W-1:0] cur_width  = hsvg_pkg::CFG_W'(hsvg_pkg::FRAME_WIDTH_RST);
  logic [hsvg_pkg::CFG_W-1:0] cur_height = hsvg_pkg::CFG_W'(hsvg_pkg::FRAME_HEIGHT_RST);

  // percent chance of starting an idle stretch, per side; changed per phase
  int src_idle_pct = 0;
  int snk_idle_pct = 0;

  int mismatch_cnt = 0;
  int stale_cycles = 0;

  hsv_rainbow_gradient_pixel_top #(
    .MAX_DIMENSION     (MAX_DIM),
    .HUE_FRACTION_BITS (HUE_F)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_col_i (pixel_col_i),
    .pixel_row_i (pixel_row_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // zero dimension acts as one, oversized ones are clipped to the maximum
  function automatic int unsigned effective_dim(input logic [hsvg_pkg::CFG_W-1:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return d;
  endfunction

  // rainbow color of one pixel under the current frame size
  function automatic hsvg_pkg::rgb_t predict_color(input pixel_t pix);
    int unsigned w;
    int unsigned hgt;
    int unsigned one_f;
    int unsigned hue;
    int unsigned seg;
    int unsigned frac;
    int unsigned v;
    int unsigned xc;
    logic [hsvg_pkg::CHAN_W-1:0] vc;
    logic [hsvg_pkg::CHAN_W-1:0] xcc;
    hsvg_pkg::hue_seg_e seg_e;
    hsvg_pkg::rgb_t c;
    w     = effective_dim(cur_width);
    hgt   = effective_dim(cur_height);
    one_f = 1 << HUE_F;
    // hue in segments, with HUE_F fraction bits
    hue  = (int'(pix.col) * hsvg_pkg::HUE_SEGMENTS * one_f) / w;
    seg  = hue >> HUE_F;
    frac = hue & (one_f - 1);
    // brightness ramps down the frame and saturates past the last row
    v = hsvg_pkg::VALUE_BASE + (hsvg_pkg::VALUE_SPAN * int'(pix.row)) / hgt;
    if (v > 255) v = 255;
    // rising edge of the ramp on even segments, falling on odd ones
    if (seg[0]) xc = (v * (one_f - frac)) >> HUE_F;
    else xc = (v * frac) >> HUE_F;
    vc  = v[hsvg_pkg::CHAN_W-1:0];
    xcc = xc[hsvg_pkg::CHAN_W-1:0];
    // columns past the width keep counting up and land in the last segment
    if (seg > hsvg_pkg::SEG_MAGENTA_TO_RED) seg_e = hsvg_pkg::SEG_MAGENTA_TO_RED;
    else seg_e = hsvg_pkg::hue_seg_e'(seg[2:0]);
    case (seg_e)
      hsvg_pkg::SEG_RED_TO_YELLOW:   c = '{vc, xcc, '0};
      hsvg_pkg::SEG_YELLOW_TO_GREEN: c = '{xcc, vc, '0};
      hsvg_pkg::SEG_GREEN_TO_CYAN:   c = '{'0, vc, xcc};
      hsvg_pkg::SEG_CYAN_TO_BLUE:    c = '{'0, xcc, vc};
      hsvg_pkg::SEG_BLUE_TO_MAGENTA: c = '{xcc, '0, vc};
      default:                       c = '{vc, '0, xcc};
    endcase
    return c;
  endfunction

  // idle stretch length: mostly short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // mostly pixels inside the frame, some on its edges, some anywhere
  function automatic pixel_t random_pixel();
    int unsigned w;
    int unsigned hgt;
    int r;
    pixel_t p;
    w   = effective_dim(cur_width);
    hgt = effective_dim(cur_height);
    r   = $urandom_range(0, 99);
    if (r < 75) begin
      p.col = hsvg_pkg::COORD_W'($urandom_range(0, w - 1));
      p.row = hsvg_pkg::COORD_W'($urandom_range(0, hgt - 1));
    end else if (r < 85) begin
      p.col = ($urandom_range(0, 1) != 0) ? hsvg_pkg::COORD_W'(w - 1) : '0;
      p.row = ($urandom_range(0, 1) != 0) ? hsvg_pkg::COORD_W'(hgt - 1) : '0;
    end else begin
      p.col = hsvg_pkg::COORD_W'($urandom);
      p.row = hsvg_pkg::COORD_W'($urandom);
    end
    return p;
  endfunction

  task automatic queue_pixel(input int col, input int row);
    pixel_t p;
    p.col = hsvg_pkg::COORD_W'(col);
    p.row = hsvg_pkg::COORD_W'(row);
    pixel_q.push_back(p);
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  // the block must be idle here; our register copy follows the write
  task automatic write_reg(input logic [hsvg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hsvg_pkg::CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      hsvg_pkg::CFG_FRAME_WIDTH:  cur_width = data;
      hsvg_pkg::CFG_FRAME_HEIGHT: cur_height = data;
      default: ;
    endcase
  endtask

  // every queued pixel sent and every expected color seen
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pixel_q.size() != 0 || in_valid_i || color_exp_q.size() != 0);
  endtask

  task automatic check_chan(input string name, input pixel_t pix,
                            input logic [hsvg_pkg::CHAN_W-1:0] got,
                            input logic [hsvg_pkg::CHAN_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("pixel (%0d,%0d) %s got %0d want %0d",
                                pix.col, pix.row, name, got, want));
  endtask

  // pixel driver: records the expected color of each accepted item and
  // offers the next one from the queue, with random idle stretches between
  always @(posedge clk_i) begin
    int in_gap;
    logic taken;
    color_exp_t e;
    pixel_t p;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap = 0;
    end else begin
      taken = in_valid_i && !in_stall_o;
      if (taken) begin
        e.pix.col = pixel_col_i;
        e.pix.row = pixel_row_i;
        e.rgb     = predict_color(e.pix);
        color_exp_q.push_back(e);
      end
      // a stalled item stays put
      if (!in_valid_i || taken) begin
        if (in_gap > 0) begin
          in_valid_i <= 1'b0;
          in_gap--;
        end else if (pixel_q.size() != 0) begin
          p = pixel_q.pop_front();
          in_valid_i  <= 1'b1;
          pixel_col_i <= p.col;
          pixel_row_i <= p.row;
          in_gap = ($urandom_range(0, 99) < src_idle_pct) ? gap_len() : 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // color monitor: compares each accepted color with the oldest expected one,
  // then picks the stall for the next cycle
  always @(posedge clk_i) begin
    int snk_hold;
    color_exp_t e;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      snk_hold = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (color_exp_q.size() == 0) begin
          report_mismatch($sformatf("color (%0d,%0d,%0d) with nothing expected",
                                    red_o, green_o, blue_o));
        end else begin
          e = color_exp_q.pop_front();
          check_chan("red", e.pix, red_o, e.rgb.red);
          check_chan("green", e.pix, green_o, e.rgb.green);
          check_chan("blue", e.pix, blue_o, e.rgb.blue);
        end
      end
      if (snk_hold > 0) begin
        out_stall_i <= 1'b1;
        snk_hold--;
      end else if ($urandom_range(0, 99) < snk_idle_pct) begin
        out_stall_i <= 1'b1;
        snk_hold = gap_len() - 1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog: give up when neither side moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stale_cycles <= 0;
    end else if (stale_cycles >= STALE_LIMIT) begin
      $display("%0t ns: no item moved for %0d cycles", $time, stale_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stale_cycles <= stale_cycles + 1;
    end
  end

  // test sequence
  initial begin
    logic [hsvg_pkg::CFG_W-1:0] w;
    logic [hsvg_pkg::CFG_W-1:0] h;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed pixels at the reset frame of 800 x 600, no idling
    src_idle_pct = 0;
    snk_idle_pct = 0;
    queue_pixel(0, 0);
    queue_pixel(799, 599);
    queue_pixel(0, 599);
    queue_pixel(799, 0);
    // both sides of each segment boundary but the one at column 400
    queue_pixel(133, 300);
    queue_pixel(134, 300);
    queue_pixel(140, 100);
    queue_pixel(266, 200);
    queue_pixel(267, 200);
    queue_pixel(400, 300);
    queue_pixel(533, 400);
    queue_pixel(534, 400);
    queue_pixel(666, 500);
    queue_pixel(667, 500);
    queue_pixel(700, 50);
    // columns past the width, rows past the height, and one pixel inside the frame
    queue_pixel(1000, 300);
    queue_pixel(300, 700);
    queue_pixel(2047, 2047);
    queue_pixel(2047, 0);
    queue_pixel(0, 2047);
    queue_pixel(1365, 1023);
    queue_pixel(682, 341);
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin w = 1;    h = 1;    end
        1: begin w = 0;    h = 0;    end  // zero acts as one
        2: begin w = 4095; h = 4095; end  // clipped to the maximum
        3: begin w = 2048; h = 2048; end
        4: begin w = 3;    h = 2047; end
        5: begin w = 2047; h = 3;    end
        default: begin
          w = ($urandom_range(0, 9) == 0) ? hsvg_pkg::CFG_W'($urandom)
                                          : hsvg_pkg::CFG_W'($urandom_range(1, 2048));
          h = ($urandom_range(0, 9) == 0) ? hsvg_pkg::CFG_W'($urandom)
                                          : hsvg_pkg::CFG_W'($urandom_range(1, 2048));
        end
      endcase
      write_reg(hsvg_pkg::CFG_FRAME_WIDTH, w);
      write_reg(hsvg_pkg::CFG_FRAME_HEIGHT, h);
      // writes to unmapped indexes must not disturb the frame
      if (p % 3 == 1)
        write_reg((p % 2 != 0) ? CFG_SPARE_B : CFG_SPARE_A, hsvg_pkg::CFG_W'($urandom));

      case (p % 4)
        0: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
        1: begin src_idle_pct = 30; snk_idle_pct = 30; end
        2: begin src_idle_pct = 70; snk_idle_pct = 10; end
        default: begin src_idle_pct = 10; snk_idle_pct = 70; end
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++)
        pixel_q.push_back(random_pixel());
      wait_drained();
    end

    // stray colors after the last expected one are caught here
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== hsv_rainbow_gradient_pixel_top.f =====
hw/rtl/hsvg_pkg.sv
hw/rtl/hsvg_div_pipe.sv
hw/rtl/hsvg_shade.sv
hw/rtl/hsvg_skid.sv
hw/rtl/hsv_rainbow_gradient_pixel_top.sv
tb/hsv_rainbow_gradient_pixel_top_tb.sv
